FILE: rtl/core/page_buffer_pool_lru_defines.svh
// Assertion macros shared by the buffer pool RTL
`ifndef PAGE_BUFFER_POOL_LRU_DEFINES_SVH
`define PAGE_BUFFER_POOL_LRU_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define PBP_ASSERT_IMPL(label, clk, rst_n, cond, expect_expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_expr)) \
        else $error(msg);

// Next-cycle implication outside reset
`define PBP_ASSERT_NEXT(label, clk, rst_n, cond, expect_expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_expr)) \
        else $error(msg);

`endif

FILE: rtl/core/pbp_pkg.sv
package pbp_pkg;

    localparam logic [2:0] KIND_PIN        = 3'd0;
    localparam logic [2:0] KIND_READ       = 3'd1;
    localparam logic [2:0] KIND_WRITE      = 3'd2;
    localparam logic [2:0] KIND_UNPIN      = 3'd3;
    localparam logic [2:0] KIND_RELEASE    = 3'd4;
    localparam logic [2:0] KIND_TEMP_PIN   = 3'd5;
    localparam logic [2:0] KIND_TEMP_UNPIN = 3'd6;
    localparam logic [2:0] KIND_UNDEF      = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  table_id;
        logic [31:0] page_num;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [3:0]  frame;
        logic        read_needed;
        logic        writeback_valid;
        logic [7:0]  writeback_table;
        logic [31:0] writeback_page;
        logic [31:0] temp_slot;
    } rsp_t;

endpackage

FILE: rtl/core/pbp_ram.sv
module pbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/page_buffer_pool_lru.sv
// Page buffer pool with LRU replacement and pinning.
// Request channel: req is sampled when start is high and busy is low.
// Response channel: rsp is valid when done is high (a one-cycle pulse) and holds until the next accept;
// the receiver cannot stall it, so no holding is needed.
// Each request walks the frame table one frame per cycle with a single
// shared compare unit: a lookup pass (S_LOOK), and for misses a free/victim
// pass (S_GRAB), plus a slot pass (S_SCAN) for new temp pages and control
// states. Hits run S_LOOK, S_DECIDE, S_DONE; pin or touch misses add S_GRAB,
// S_GOT, S_FIN; unpinned temp pages run S_POP, S_SLOT, S_SCAN, S_DONE and
// pinned temp pages S_GRAB, S_GOT, S_POP, S_SLOT, S_SCAN, S_FIN, S_DONE (no
// lookup); busy stays high for the whole request, so no new request is
// taken until it ends. The free-slot stack lives in a RAM with registered read.
// Reset clears all frames to free, the tick and temp-slot counters and the
// stack count; stack contents are undefined until pushed.
// done is a registered pulse, raised from the S_DONE state that ends every request.
module page_buffer_pool_lru #(
    parameter int NUM_FRAMES      = 16,
    parameter int FREE_SLOT_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pbp_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output pbp_pkg::rsp_t rsp
);

`include "page_buffer_pool_lru_defines.svh"

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int SW = $clog2(FREE_SLOT_DEPTH);
    localparam logic [31:0] RECENT = 32'(NUM_FRAMES / 2);
    localparam logic [FW-1:0] LAST_F = FW'(NUM_FRAMES - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOK   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_GRAB   = 4'd3;
    localparam logic [3:0] S_GOT    = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_SLOT   = 4'd6;
    localparam logic [3:0] S_SCAN   = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // frame table
    logic [7:0]  owner_reg [NUM_FRAMES];
    logic [31:0] pnum_reg  [NUM_FRAMES];
    logic [31:0] stamp_reg [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] used_reg, pin_reg, dirty_reg;
    logic [31:0] tick_reg;
    logic [31:0] next_slot_reg;
    logic [SW:0] fcount_reg;

    logic [3:0]    state_reg;
    pbp_pkg::req_t q_reg;
    pbp_pkg::rsp_t r_reg;
    logic [FW-1:0] idx_reg;
    logic          found_reg, free_found_reg, vict_found_reg;
    logic [FW-1:0] hit_f_reg, free_f_reg, vict_f_reg, tgt_reg;
    logic [31:0]   best_reg;
    logic [31:0]   slot_reg;
    logic          done_reg;

    // stack RAM
    logic          ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;

    pbp_ram #(.WIDTH(32), .DEPTH(FREE_SLOT_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.page_num),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // push at accept time for a temp-file release
    assign ram_we    = start && !busy && (req.kind == pbp_pkg::KIND_RELEASE)
                       && (req.table_id == 8'd0)
                       && (fcount_reg < (SW+1)'(FREE_SLOT_DEPTH));
    assign ram_waddr = fcount_reg[SW-1:0];
    assign ram_raddr = SW'(fcount_reg - (SW+1)'(1));

    // shared per-frame compare unit
    logic [31:0] cur_age;
    logic        cur_match, cur_slot_match;
    assign cur_age        = tick_reg - stamp_reg[idx_reg];
    assign cur_match      = used_reg[idx_reg] && owner_reg[idx_reg] == q_reg.table_id
                            && pnum_reg[idx_reg] == q_reg.page_num;
    assign cur_slot_match = used_reg[idx_reg] && owner_reg[idx_reg] == 8'd0
                            && pnum_reg[idx_reg] == slot_reg;

    logic is_temp, is_touch;
    assign is_temp  = q_reg.kind == pbp_pkg::KIND_TEMP_PIN
                      || q_reg.kind == pbp_pkg::KIND_TEMP_UNPIN;
    assign is_touch = q_reg.kind == pbp_pkg::KIND_READ || q_reg.kind == pbp_pkg::KIND_WRITE;

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            pin_reg        <= '0;
            dirty_reg      <= '0;
            tick_reg       <= '0;
            next_slot_reg  <= '0;
            fcount_reg     <= '0;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
            q_reg          <= '0;
            r_reg          <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            vict_found_reg <= 1'b0;
            hit_f_reg      <= '0;
            free_f_reg     <= '0;
            vict_f_reg     <= '0;
            tgt_reg        <= '0;
            best_reg       <= '0;
            slot_reg       <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                owner_reg[i] <= '0;
                pnum_reg[i]  <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        q_reg          <= req;
                        r_reg          <= '0;
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        vict_found_reg <= 1'b0;
                        if (ram_we)
                        begin
                            fcount_reg <= fcount_reg + (SW+1)'(1);
                        end
                        if (req.kind == pbp_pkg::KIND_TEMP_PIN)
                        begin
                            state_reg <= S_GRAB;
                        end
                        else if (req.kind == pbp_pkg::KIND_TEMP_UNPIN)
                        begin
                            state_reg <= S_POP;
                        end
                        else if (req.kind == pbp_pkg::KIND_UNDEF)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_LOOK;
                        end
                    end
                end
                // lookup pass: first matching frame
                S_LOOK:
                begin
                    if (cur_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_f_reg <= idx_reg;
                    end
                    idx_reg <= idx_reg + FW'(1);
                    if (idx_reg == LAST_F)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    idx_reg <= '0;
                    if (found_reg)
                    begin
                        r_reg.hit   <= 1'b1;
                        r_reg.frame <= 4'(hit_f_reg);
                        state_reg   <= S_DONE;
                        case (q_reg.kind)
                            pbp_pkg::KIND_PIN:
                            begin
                                pin_reg[hit_f_reg] <= 1'b1;
                            end
                            pbp_pkg::KIND_READ, pbp_pkg::KIND_WRITE:
                            begin
                                if (!pin_reg[hit_f_reg] &&
                                    (tick_reg - stamp_reg[hit_f_reg]) >= RECENT)
                                begin
                                    tick_reg <= tick_reg + 32'd1;
                                    stamp_reg[hit_f_reg] <= tick_reg + 32'd1;
                                end
                                if (q_reg.kind == pbp_pkg::KIND_WRITE)
                                begin
                                    dirty_reg[hit_f_reg] <= 1'b1;
                                end
                            end
                            default:
                            begin
                                // unpin or release
                                if (pin_reg[hit_f_reg])
                                begin
                                    pin_reg[hit_f_reg]   <= 1'b0;
                                    tick_reg             <= tick_reg + 32'd1;
                                    stamp_reg[hit_f_reg] <= tick_reg + 32'd1;
                                end
                                else if (q_reg.kind == pbp_pkg::KIND_RELEASE)
                                begin
                                    if (dirty_reg[hit_f_reg])
                                    begin
                                        r_reg.writeback_valid <= 1'b1;
                                        r_reg.writeback_table <= q_reg.table_id;
                                        r_reg.writeback_page  <= q_reg.page_num;
                                    end
                                    used_reg[hit_f_reg]  <= 1'b0;
                                    dirty_reg[hit_f_reg] <= 1'b0;
                                    owner_reg[hit_f_reg] <= '0;
                                    pnum_reg[hit_f_reg]  <= '0;
                                    stamp_reg[hit_f_reg] <= '0;
                                end
                            end
                        endcase
                    end
                    else if (q_reg.kind == pbp_pkg::KIND_UNPIN
                             || q_reg.kind == pbp_pkg::KIND_RELEASE)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_GRAB;
                    end
                end
                // free / victim pass: lowest free frame, else oldest unpinned
                S_GRAB:
                begin
                    if (!used_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_f_reg     <= idx_reg;
                    end
                    if (!pin_reg[idx_reg] && (!vict_found_reg || cur_age > best_reg))
                    begin
                        vict_found_reg <= 1'b1;
                        vict_f_reg     <= idx_reg;
                        best_reg       <= cur_age;
                    end
                    idx_reg <= idx_reg + FW'(1);
                    if (idx_reg == LAST_F)
                    begin
                        state_reg <= S_GOT;
                    end
                end
                S_GOT:
                begin
                    idx_reg <= '0;
                    if (free_found_reg)
                    begin
                        tgt_reg   <= free_f_reg;
                        state_reg <= is_temp ? S_POP : S_FIN;
                    end
                    else if (vict_found_reg)
                    begin
                        tgt_reg <= vict_f_reg;
                        if (dirty_reg[vict_f_reg])
                        begin
                            r_reg.writeback_valid <= 1'b1;
                            r_reg.writeback_table <= owner_reg[vict_f_reg];
                            r_reg.writeback_page  <= pnum_reg[vict_f_reg];
                        end
                        used_reg[vict_f_reg]  <= 1'b0;
                        pin_reg[vict_f_reg]   <= 1'b0;
                        dirty_reg[vict_f_reg] <= 1'b0;
                        owner_reg[vict_f_reg] <= '0;
                        pnum_reg[vict_f_reg]  <= '0;
                        stamp_reg[vict_f_reg] <= '0;
                        state_reg <= is_temp ? S_POP : S_FIN;
                    end
                    else
                    begin
                        r_reg.status <= 1'b1;
                        state_reg    <= S_DONE;
                    end
                end
                // take a slot: pop the stack (RAM read issued now) or count
                S_POP:
                begin
                    idx_reg <= '0;
                    if (fcount_reg != '0)
                    begin
                        fcount_reg <= fcount_reg - (SW+1)'(1);
                        found_reg  <= 1'b1;
                    end
                    else
                    begin
                        found_reg     <= 1'b0;
                        slot_reg      <= next_slot_reg;
                        next_slot_reg <= next_slot_reg + 32'd1;
                    end
                    state_reg <= S_SLOT;
                end
                S_SLOT:
                begin
                    if (found_reg)
                    begin
                        slot_reg <= ram_rdata;
                    end
                    state_reg <= S_SCAN;
                end
                // free any stale frame that holds the handed-out slot
                S_SCAN:
                begin
                    if (cur_slot_match)
                    begin
                        used_reg[idx_reg]  <= 1'b0;
                        pin_reg[idx_reg]   <= 1'b0;
                        dirty_reg[idx_reg] <= 1'b0;
                        owner_reg[idx_reg] <= '0;
                        pnum_reg[idx_reg]  <= '0;
                        stamp_reg[idx_reg] <= '0;
                    end
                    idx_reg <= idx_reg + FW'(1);
                    if (idx_reg == LAST_F)
                    begin
                        r_reg.temp_slot <= slot_reg;
                        state_reg <= (q_reg.kind == pbp_pkg::KIND_TEMP_PIN) ? S_FIN : S_DONE;
                    end
                end
                // install page into the chosen frame
                S_FIN:
                begin
                    used_reg[tgt_reg]  <= 1'b1;
                    owner_reg[tgt_reg] <= is_temp ? 8'd0 : q_reg.table_id;
                    pnum_reg[tgt_reg]  <= is_temp ? slot_reg : q_reg.page_num;
                    r_reg.frame        <= 4'(tgt_reg);
                    r_reg.read_needed  <= !is_temp;
                    dirty_reg[tgt_reg] <= q_reg.kind == pbp_pkg::KIND_WRITE;
                    if (is_touch)
                    begin
                        pin_reg[tgt_reg]   <= 1'b0;
                        tick_reg           <= tick_reg + 32'd1;
                        stamp_reg[tgt_reg] <= tick_reg + 32'd1;
                    end
                    else
                    begin
                        pin_reg[tgt_reg]   <= 1'b1;
                        stamp_reg[tgt_reg] <= tick_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PBP_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request not busy")
    `PBP_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !done, "done longer than one cycle")
    `PBP_ASSERT_IMPL(a_stack_bound, clk, rst_n, 1'b1,
        fcount_reg <= (SW+1)'(FREE_SLOT_DEPTH), "stack count overflow")
    `PBP_ASSERT_IMPL(a_nostat_frame, clk, rst_n, done && rsp.status,
        rsp.frame == 4'd0 && !rsp.hit, "failed request reports a frame")

endmodule
